### hw/rtl/cpx_pkg.sv
// ----------------------------------------------------------------------------
// cpx_pkg
// types and constants shared by the charlieplex single node driver
// ----------------------------------------------------------------------------
`default_nettype none

package cpx_pkg;

    localparam int LINE_W    = 4;
    localparam int IDX_W     = 8;
    localparam int DRIVE_W   = 16;
    localparam int CNT_W     = 5;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic CFG_IDX_LINE_COUNT  = 1'b0;
    localparam logic CFG_IDX_COMMON_TYPE = 1'b1;

    localparam logic [CNT_W-1:0] LINE_COUNT_RESET  = 5'd16;
    localparam logic             COMMON_TYPE_RESET = 1'b1;
    localparam logic [CNT_W-1:0] MIN_LINES         = 5'd2;

    typedef enum logic [1:0] {
        ACT_ON    = 2'b00,
        ACT_OFF   = 2'b01,
        ACT_CLEAR = 2'b10,
        ACT_RESET = 2'b11
    } cpx_action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_EVAL,
        ST_OUT
    } cpx_state_t;

    typedef struct packed {
        cpx_action_t        action;
        logic               by_index;
        logic [4:0]         row;
        logic [3:0]         col;
        logic [IDX_W-1:0]   node_index;
    } cpx_req_t;

    typedef struct packed {
        logic               ok;
        logic [DRIVE_W-1:0] drive_enable;
        logic [DRIVE_W-1:0] drive_level;
    } cpx_rsp_t;

endpackage

`default_nettype wire

### hw/rtl/cpx_divider.sv
// ----------------------------------------------------------------------------
// cpx_divider
// restoring divider, one quotient bit per cycle, for linear node addressing
// ----------------------------------------------------------------------------
`default_nettype none

module cpx_divider
    import cpx_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [IDX_W-1:0]  dividend,
    input  wire logic [LINE_W-1:0] divisor,
    output logic                   done,
    output logic [IDX_W-1:0]       quotient,
    output logic [LINE_W-1:0]      remainder
);

    localparam int STEP_W = $clog2(IDX_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(IDX_W - 1);

    logic                busy_reg, busy_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]    quo_reg, quo_next;
    logic [LINE_W-1:0]   rem_reg, rem_next;
    logic [LINE_W-1:0]   dvs_reg, dvs_next;
    logic [LINE_W:0]     trial;
    logic                fits;

    assign trial = {rem_reg, quo_reg[IDX_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? LINE_W'(trial - {1'b0, dvs_reg}) : trial[LINE_W-1:0];
            quo_next = {quo_reg[IDX_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = busy_reg && (cnt_reg == LAST_STEP);
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

### hw/rtl/charlieplex_single_node_driver.sv
// ----------------------------------------------------------------------------
// charlieplex_single_node_driver
// lights at most one node of a charlieplexed diode matrix on tri-state lines
// ----------------------------------------------------------------------------
// sequence: accept in IDLE, then PREP, EVAL (result registered) and OUT;
//   an in-range linear index ON or OFF adds DIV for the 8 divider steps
// one item in flight at a time
// reset: asynchronous active low; nothing lit, line_count 16, common_type 1
`default_nettype none

module charlieplex_single_node_driver
    import cpx_pkg::*;
#(
    parameter int MAX_LINES = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_stall,
    input  wire cpx_req_t              req,
    output logic                       rsp_valid,
    input  wire logic                  rsp_stall,
    output cpx_rsp_t                   rsp,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_LINES);

    cpx_state_t          state_reg, state_next;
    cpx_req_t            req_reg;
    cpx_rsp_t            rsp_reg, rsp_next;
    logic [CNT_W-1:0]    line_count_reg;
    logic                common_type_reg;
    logic                lit_reg, lit_next;
    logic [LINE_W-1:0]   hi_reg, hi_next;
    logic [LINE_W-1:0]   lo_reg, lo_next;

    logic                cfg_wr;
    logic                req_take;
    logic                div_start;
    logic                div_done;
    logic                eval_en;
    logic [IDX_W-1:0]    div_quo;
    logic [LINE_W-1:0]   div_rem;

    logic [CNT_W-1:0]    n;
    logic [CNT_W-1:0]    n_m1;
    logic [2*CNT_W-1:0]  node_total;
    logic                in_range;
    logic                need_div;
    logic [LINE_W-1:0]   r0, c0;
    logic [LINE_W-1:0]   rl, cl;
    logic [LINE_W-1:0]   hi, lo;
    logic                ok;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg  <= LINE_COUNT_RESET;
            common_type_reg <= COMMON_TYPE_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == CFG_IDX_LINE_COUNT)
            begin
                line_count_reg <= pwdata[CNT_W-1:0];
            end
            else
            begin
                common_type_reg <= pwdata[0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == CFG_IDX_COMMON_TYPE)
        begin
            prdata[0] = common_type_reg;
        end
        else
        begin
            prdata[CNT_W-1:0] = line_count_reg;
        end
    end

    // address range and decode
    assign n = (line_count_reg < MIN_LINES) ? MIN_LINES :
               (line_count_reg > MAX_N) ? MAX_N : line_count_reg;
    assign n_m1       = n - 1'b1;
    assign node_total = n * n_m1;

    always_comb
    begin
        if (req_reg.by_index)
        begin
            in_range = (req_reg.node_index != '0) &&
                       ({{(2*CNT_W-IDX_W){1'b0}}, req_reg.node_index} <= node_total);
        end
        else
        begin
            in_range = (req_reg.row != '0) && (req_reg.row <= n) &&
                       (req_reg.col != '0) && ({1'b0, req_reg.col} <= n_m1);
        end
    end

    assign need_div = req_reg.by_index && in_range &&
                      ((req_reg.action == ACT_ON) || (req_reg.action == ACT_OFF));

    cpx_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (req_reg.node_index - 1'b1),
        .divisor   (n_m1[LINE_W-1:0]),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign r0 = div_quo[LINE_W-1:0];
    assign c0 = div_rem;

    always_comb
    begin
        if (req_reg.by_index)
        begin
            rl = r0;
            cl = (c0 < r0) ? c0 : c0 + 1'b1;
        end
        else
        begin
            rl = LINE_W'(req_reg.row - 1'b1);
            cl = ({1'b0, req_reg.col} < req_reg.row) ? req_reg.col - 1'b1 : req_reg.col;
        end
    end

    assign hi = common_type_reg ? rl : cl;
    assign lo = common_type_reg ? cl : rl;

    // request evaluation
    always_comb
    begin
        lit_next = lit_reg;
        hi_next  = hi_reg;
        lo_next  = lo_reg;
        ok       = 1'b0;
        case (req_reg.action)
            ACT_ON:
            begin
                if (in_range)
                begin
                    lit_next = 1'b1;
                    hi_next  = hi;
                    lo_next  = lo;
                    ok       = 1'b1;
                end
            end
            ACT_OFF:
            begin
                if (in_range)
                begin
                    if (!lit_reg)
                    begin
                        ok = 1'b1;
                    end
                    else if ((hi == hi_reg) && (lo == lo_reg))
                    begin
                        lit_next = 1'b0;
                        hi_next  = '0;
                        lo_next  = '0;
                        ok       = 1'b1;
                    end
                    else if ((hi != hi_reg) && (hi != lo_reg) &&
                             (lo != hi_reg) && (lo != lo_reg))
                    begin
                        ok = 1'b1;
                    end
                end
            end
            default:
            begin
                lit_next = 1'b0;
                hi_next  = '0;
                lo_next  = '0;
                ok       = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        rsp_next.ok           = ok;
        rsp_next.drive_enable = '0;
        rsp_next.drive_level  = '0;
        if (lit_next)
        begin
            rsp_next.drive_enable = (DRIVE_W'(1) << hi_next) | (DRIVE_W'(1) << lo_next);
            rsp_next.drive_level  = DRIVE_W'(1) << hi_next;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = need_div ? ST_DIV : ST_EVAL;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!rsp_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall = 1'b1;
        rsp_valid = 1'b0;
        div_start = 1'b0;
        eval_en   = 1'b0;
        case (state_reg)
            ST_IDLE: req_stall = 1'b0;
            ST_PREP: div_start = need_div;
            ST_EVAL: eval_en   = 1'b1;
            ST_OUT:  rsp_valid = 1'b1;
            default: req_stall = 1'b1;
        endcase
    end

    assign req_take = req_valid && !req_stall;
    assign rsp      = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lit_reg   <= 1'b0;
            hi_reg    <= '0;
            lo_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (eval_en)
            begin
                lit_reg <= lit_next;
                hi_reg  <= hi_next;
                lo_reg  <= lo_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            req_reg <= req;
        end
        if (eval_en)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // checks
    a_dark_lines_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !lit_reg |-> (hi_reg == '0) && (lo_reg == '0))
        else $error("dark node holds nonzero lines");

    a_lit_lines_differ: assert property (@(posedge clk) disable iff (!rst_n)
        lit_reg |-> (hi_reg != lo_reg))
        else $error("lit node has anode equal to cathode");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_take |=> req_stall && !rsp_valid)
        else $error("item accepted without entering the sequence");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

endmodule

`default_nettype wire
